[hw/rtl/pnc_pkg.sv]
// ----------------------------------------------------------------------------
// pnc_pkg: shared definitions for the prefixed number converter
// Character codes, form codes, radix constants, item and result types, and
// the digit decoder used by the token logic.
// ----------------------------------------------------------------------------
package pnc_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned RadixW  = 6;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned PosW    = 8;

  localparam logic [ChW-1:0] CharPercent = 8'h25;  // '%'
  localparam logic [ChW-1:0] CharHash    = 8'h23;  // '#'
  localparam logic [ChW-1:0] CharDollar  = 8'h24;  // '$'
  localparam logic [ChW-1:0] CharQuote   = 8'h27;  // single quote
  localparam logic [ChW-1:0] CharMinus   = 8'h2d;  // '-'
  localparam logic [ChW-1:0] CharZero    = 8'h30;  // '0'
  localparam logic [ChW-1:0] CharNine    = 8'h39;  // '9'
  localparam logic [ChW-1:0] CharLowA    = 8'h61;  // 'a'
  localparam logic [ChW-1:0] CharLowZ    = 8'h7a;  // 'z'
  localparam logic [ChW-1:0] CharUpA     = 8'h41;  // 'A'
  localparam logic [ChW-1:0] CharUpZ     = 8'h5a;  // 'Z'

  localparam logic [RadixW-1:0] RadixBin     = 6'd2;
  localparam logic [RadixW-1:0] RadixDec     = 6'd10;
  localparam logic [RadixW-1:0] RadixHex     = 6'd16;
  localparam logic [RadixW-1:0] DigitNone    = 6'd36;
  localparam logic [RadixW-1:0] DigitLetter  = 6'd10;
  localparam logic [RadixW-1:0] DefaultBaseRst = RadixDec;

  localparam logic [PosW-1:0] PosMax    = 8'd255;
  localparam logic [PosW-1:0] PosQuoted = 8'd3;

  localparam logic [1:0] FormPlain    = 2'd0;
  localparam logic [1:0] FormPrefixed = 2'd1;
  localparam logic [1:0] FormQuoted   = 2'd2;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           last;
    logic           empty_token;
  } pnc_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ok;
  } pnc_result_t;

  // Digit value 0..35, or DigitNone when the character is no digit.
  function automatic logic [RadixW-1:0] digit_value(input logic [ChW-1:0] ch);
    logic [ChW-1:0] diff;
    diff = '0;
    if (ch >= CharZero && ch <= CharNine) begin
      diff = ch - CharZero;
      return diff[RadixW-1:0];
    end else if (ch >= CharLowA && ch <= CharLowZ) begin
      diff = ch - CharLowA;
      return diff[RadixW-1:0] + DigitLetter;
    end else if (ch >= CharUpA && ch <= CharUpZ) begin
      diff = ch - CharUpA;
      return diff[RadixW-1:0] + DigitLetter;
    end
    return DigitNone;
  endfunction

endpackage

[hw/rtl/pnc_in_if.sv]
// ----------------------------------------------------------------------------
// pnc_in_if: character item channel
// Valid/ready channel that carries one character of a token per item.
// ----------------------------------------------------------------------------
interface pnc_in_if;
  logic                    valid;
  logic                    ready;
  logic [pnc_pkg::ChW-1:0] ch;
  logic                    last;
  logic                    empty_token;

  modport source (output valid, output ch, output last, output empty_token,
                  input ready);
  modport sink   (input valid, input ch, input last, input empty_token,
                  output ready);
endinterface

[hw/rtl/pnc_out_if.sv]
// ----------------------------------------------------------------------------
// pnc_out_if: result item channel
// Valid/ready channel that carries one converted value and its ok flag.
// ----------------------------------------------------------------------------
interface pnc_out_if;
  logic                       valid;
  logic                       ready;
  logic [pnc_pkg::ValueW-1:0] value;
  logic                       ok;

  modport source (output valid, output value, output ok, input ready);
  modport sink   (input valid, input value, input ok, output ready);
endinterface

[hw/rtl/prefixed_number_converter_top.sv]
// ----------------------------------------------------------------------------
// prefixed_number_converter_top: token to cell value converter
// Converts a token of number characters, given one character per item, into
// a cell value with an ok flag, in the style of a Forth number parser.
// ----------------------------------------------------------------------------
// The block takes one character item per clock cycle while the result
// register can move, and gives one result item after the final character of
// a token has passed the input register and then the result register. The
// rate of one character per cycle is set by the multiply-add that folds each
// digit into the accumulator, accumulator * radix + digit, which is
// combinational between the input register and the result register. A token
// may be a quoted character ('c'), a prefixed number (% binary, # decimal,
// $ hexadecimal, optionally followed by one '-'), a negative number with a
// leading '-', or plain digits in the radix held in the default_base
// register. Digits 0-9 and letters in either case are valid below the radix.
// The accumulator is CELL_BITS wide and wraps; a negative token gives the
// two's complement of it, and the result carries its low 16 bits. An invalid
// token, or an item marked as an empty token, gives ok low and value zero.
// The radix register is sampled at the first character of each token, so it
// should be written only between tokens. The result register decouples the
// two sides only in part: a new character can still enter an empty input
// register while a finished result waits to be taken.
// ----------------------------------------------------------------------------
module prefixed_number_converter_top #(
  parameter int unsigned CELL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pnc_pkg::RadixW-1:0]   cfg_wdata_i,
  pnc_in_if.sink                       in_i,
  pnc_out_if.source                    out_o
);
  import pnc_pkg::*;

  logic [RadixW-1:0] default_base_q;
  pnc_item_t         in_item;
  pnc_item_t         cur_item;
  logic              in_valid_q;
  logic              advance;
  logic              step;
  logic              res_valid;
  pnc_result_t       res;
  pnc_result_t       out_res;

  // Radix for tokens that carry no prefix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_base_q <= DefaultBaseRst;
    end else if (cfg_we_i) begin
      default_base_q <= cfg_wdata_i;
    end
  end

  assign in_item.ch          = in_i.ch;
  assign in_item.last        = in_i.last;
  assign in_item.empty_token = in_i.empty_token;

  pnc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (in_valid_q),
    .item_o    (cur_item)
  );

  // A held character is processed whenever the result register can move.
  assign step = in_valid_q && advance;

  pnc_token_core #(
    .CELL_BITS (CELL_BITS)
  ) u_token_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (cur_item),
    .default_base_i (default_base_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  pnc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_i     (out_o.ready),
    .valid_o     (out_o.valid),
    .res_o       (out_res),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance)
  );

  assign out_o.value = out_res.value;
  assign out_o.ok    = out_res.ok;

  // A rejected token always reports a zero value.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ok |-> out_o.value == '0)
    else $error("invalid result with nonzero value");

  // An accepted character is held in the input register in the next cycle.
  a_in_capture : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> in_valid_q)
    else $error("accepted item not captured");

  // A full input register behind a stalled result blocks new characters.
  a_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while pipeline is stalled");

  // A result can only enter the output when a character was processed.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid && !in_valid_q |=> !out_o.valid)
    else $error("result appeared without a processed item");
endmodule

[hw/rtl/pnc_in_reg.sv]
// ----------------------------------------------------------------------------
// pnc_in_reg: input register
// Holds one accepted character item until the token logic consumes it.
// ----------------------------------------------------------------------------
module pnc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  pnc_pkg::pnc_item_t item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output pnc_pkg::pnc_item_t item_o
);
  import pnc_pkg::*;

  logic      valid_q, valid_d;
  pnc_item_t item_q;
  logic      load;

  // The register frees up in the same cycle that its item moves on.
  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

[hw/rtl/pnc_token_core.sv]
// ----------------------------------------------------------------------------
// pnc_token_core: per-character token logic
// Keeps the token state, folds in one character per step with a single
// multiply-add, and forms the result at the end of a token.
// ----------------------------------------------------------------------------
module pnc_token_core #(
  parameter int unsigned CELL_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  pnc_pkg::pnc_item_t              item_i,
  input  logic [pnc_pkg::RadixW-1:0]      default_base_i,
  output logic                            res_valid_o,
  output pnc_pkg::pnc_result_t            res_o
);
  import pnc_pkg::*;

  localparam int unsigned ProdW = CELL_BITS + RadixW;

  logic [PosW-1:0]      pos_q, pos_d;
  logic [RadixW-1:0]    radix_q, radix_d;
  logic [1:0]           form_q, form_d;
  logic                 neg_q, neg_d;
  logic                 err_q, err_d;
  logic                 seen_q, seen_d;
  logic [CELL_BITS-1:0] acc_q, acc_d;
  logic [ChW-1:0]       qc_q, qc_d;

  logic                 at_start;
  logic [RadixW-1:0]    digit;
  logic [RadixW-1:0]    radix_use;
  logic                 digit_ok;
  logic                 take;
  logic [ProdW-1:0]     prod;
  logic [CELL_BITS-1:0] mac;
  logic [CELL_BITS-1:0] cell_val;
  logic [CELL_BITS+ValueW-1:0] cell_ext;
  logic                 ends;
  logic                 ok;

  assign at_start = (pos_q == '0);
  assign digit    = digit_value(item_i.ch);

  // At the first character the radix comes from the prefix or the register.
  always_comb begin
    radix_use = radix_q;
    if (at_start) begin
      case (item_i.ch)
        CharPercent: radix_use = RadixBin;
        CharHash:    radix_use = RadixDec;
        CharDollar:  radix_use = RadixHex;
        default:     radix_use = default_base_i;
      endcase
    end
  end

  assign digit_ok = (digit < DigitNone) && (digit < radix_use);
  assign prod     = ProdW'(acc_q) * ProdW'(radix_use);
  assign mac      = prod[CELL_BITS-1:0] + CELL_BITS'(digit);
  assign ends     = step_i && (item_i.last || item_i.empty_token);

  always_comb begin
    pos_d   = pos_q;
    radix_d = radix_q;
    form_d  = form_q;
    neg_d   = neg_q;
    err_d   = err_q;
    seen_d  = seen_q;
    acc_d   = acc_q;
    qc_d    = qc_q;
    take    = 1'b0;

    if (at_start) begin
      radix_d = radix_use;
      case (item_i.ch)
        CharQuote:   form_d = FormQuoted;
        CharPercent: form_d = FormPrefixed;
        CharHash:    form_d = FormPrefixed;
        CharDollar:  form_d = FormPrefixed;
        default: begin
          form_d = FormPlain;
          if (item_i.ch == CharMinus) begin
            neg_d = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
      endcase
    end else if (form_q == FormQuoted) begin
      if (pos_q == PosW'(1)) begin
        qc_d = item_i.ch;
      end else if (pos_q != PosW'(2) || item_i.ch != CharQuote) begin
        err_d = 1'b1;
      end
    end else if (item_i.ch == CharMinus) begin
      // A sign is allowed right after a prefix, once.
      if (pos_q == PosW'(1) && form_q == FormPrefixed && !neg_q) begin
        neg_d = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (digit_ok) begin
        acc_d  = mac;
        seen_d = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end

    if (pos_q != PosMax) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  // Result of a token that ends with this character.
  always_comb begin
    cell_val = neg_d ? (CELL_BITS'(0) - acc_d) : acc_d;
    if (form_d == FormQuoted) begin
      ok       = !err_d && (pos_d == PosQuoted);
      cell_val = CELL_BITS'(qc_d);
    end else begin
      ok = !err_d && seen_d;
    end
    cell_ext = {{ValueW{1'b0}}, cell_val};
    if (item_i.empty_token || !ok) begin
      res_o.value = '0;
      res_o.ok    = 1'b0;
    end else begin
      res_o.value = cell_ext[ValueW-1:0];
      res_o.ok    = 1'b1;
    end
  end

  assign res_valid_o = ends;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      radix_q <= RadixDec;
      form_q  <= FormPlain;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= '0;
      qc_q    <= '0;
    end else if (ends) begin
      pos_q   <= '0;
      radix_q <= RadixDec;
      form_q  <= FormPlain;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= '0;
      qc_q    <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      radix_q <= radix_d;
      form_q  <= form_d;
      neg_q   <= neg_d;
      err_q   <= err_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
      qc_q    <= qc_d;
    end
  end
endmodule

[hw/rtl/pnc_out_reg.sv]
// ----------------------------------------------------------------------------
// pnc_out_reg: result register
// Holds a finished result item until the sink takes it and tells the
// upstream stage when it may move on.
// ----------------------------------------------------------------------------
module pnc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ready_i,
  output logic                 valid_o,
  output pnc_pkg::pnc_result_t res_o,
  input  logic                 res_valid_i,
  input  pnc_pkg::pnc_result_t res_i,
  output logic                 advance_o
);
  import pnc_pkg::*;

  logic        valid_q, valid_d;
  pnc_result_t res_q;

  assign advance_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

[verif/tb_prefixed_number_converter_top.sv]
// ----------------------------------------------------------------------------
// tb_prefixed_number_converter_top: self-checking bench for the converter
// Feeds tokens one character item at a time and predicts each converted
// value and ok flag. Covers directed forms, radix register settings, overlong
// tokens and a long random mix, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_prefixed_number_converter_top;
  import pnc_pkg::*;

  localparam int unsigned CellBits = 16;
  localparam int unsigned RandomItems = 500;
  // Drain margin after the final character, past the input and result registers.
  localparam int unsigned DrainCycles = 6;
  localparam logic [RadixW-1:0] NoDigit = 6'd36;

  typedef logic [ChW-1:0] char_q_t[$];

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [RadixW-1:0] cfg_wdata_i;

  pnc_in_if in_if ();
  pnc_out_if out_if ();

  prefixed_number_converter_top #(
    .CELL_BITS(CellBits)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the block: the radix register and the state of the token that
  // is being parsed. The token state is cleared after every result.
  logic [RadixW-1:0]   base_reg;
  logic [PosW-1:0]     tok_pos;
  logic [RadixW-1:0]   tok_radix;
  logic [1:0]          tok_form;
  bit                  tok_neg;
  bit                  tok_err;
  bit                  tok_seen;
  logic [CellBits-1:0] tok_acc;
  logic [ChW-1:0]      tok_qchar;

  // Conversions predicted but not yet seen on the result channel, oldest
  // first.
  pnc_result_t conversion_q[$];

  // When idling is off, both sides run flat out.
  bit idle_on;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned tokens_sent;
  int unsigned good_numbers;
  int unsigned rejected_tokens;
  int unsigned base_writes;

  function automatic void clear_token();
    tok_pos   = '0;
    tok_radix = RadixDec;
    tok_form  = FormPlain;
    tok_neg   = 1'b0;
    tok_err   = 1'b0;
    tok_seen  = 1'b0;
    tok_acc   = '0;
    tok_qchar = '0;
  endfunction

  // Digit weight of a character in any radix up to 36, or NoDigit.
  function automatic logic [RadixW-1:0] char_digit(logic [ChW-1:0] c);
    if (c >= CharZero && c <= CharNine) return RadixW'(c - CharZero);
    if (c >= CharLowA && c <= CharLowZ) return RadixW'(c - CharLowA + 8'd10);
    if (c >= CharUpA && c <= CharUpZ) return RadixW'(c - CharUpA + 8'd10);
    return NoDigit;
  endfunction

  // Folds one digit into the accumulator; a digit at or above the radix
  // spoils the token. The multiply wraps at the cell width.
  function automatic void fold_digit(logic [ChW-1:0] c);
    logic [RadixW-1:0] d;
    d = char_digit(c);
    if (d >= NoDigit || d >= tok_radix) begin
      tok_err = 1'b1;
    end else begin
      tok_acc  = CellBits'(tok_acc * tok_radix + d);
      tok_seen = 1'b1;
    end
  endfunction

  // Advances the token state by one accepted character item and queues the
  // conversion when the item ends the token.
  function automatic void parse_char(logic [ChW-1:0] c, bit lst, bit emp);
    pnc_result_t res;
    bit good;
    logic [CellBits-1:0] cell_val;
    res = '0;
    if (emp) begin
      // An empty token ends at once and throws away whatever came before.
      conversion_q.push_back(res);
      clear_token();
      return;
    end
    if (tok_pos == '0) begin
      case (c)
        CharQuote: tok_form = FormQuoted;
        CharPercent: begin
          tok_form  = FormPrefixed;
          tok_radix = RadixBin;
        end
        CharHash: begin
          tok_form  = FormPrefixed;
          tok_radix = RadixDec;
        end
        CharDollar: begin
          tok_form  = FormPrefixed;
          tok_radix = RadixHex;
        end
        default: begin
          // The default radix is latched here, at the first character.
          tok_form  = FormPlain;
          tok_radix = base_reg;
          if (c == CharMinus) tok_neg = 1'b1;
          else fold_digit(c);
        end
      endcase
    end else if (tok_form == FormQuoted) begin
      if (tok_pos == 8'd1) tok_qchar = c;
      else if (tok_pos != 8'd2 || c != CharQuote) tok_err = 1'b1;
    end else if (c == CharMinus) begin
      // A sign is allowed only right after a prefix, and only once.
      if (tok_pos == 8'd1 && tok_form == FormPrefixed && !tok_neg) tok_neg = 1'b1;
      else tok_err = 1'b1;
    end else begin
      fold_digit(c);
    end
    if (tok_pos != PosMax) tok_pos = tok_pos + 8'd1;
    if (!lst) return;
    if (tok_form == FormQuoted) begin
      good     = !tok_err && tok_pos == PosQuoted;
      cell_val = CellBits'(tok_qchar);
    end else begin
      good     = !tok_err && tok_seen;
      cell_val = tok_neg ? CellBits'('0 - tok_acc) : tok_acc;
    end
    res.ok    = good;
    res.value = good ? ValueW'(cell_val) : '0;
    conversion_q.push_back(res);
    clear_token();
  endfunction

  // Sends one character item, after a random gap while idling is on, and
  // predicts its effect once it is accepted. Valid stays high after
  // acceptance so that back-to-back items need no extra edge.
  task automatic send_char(input logic [ChW-1:0] c, input bit lst, input bit emp);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.ch          <= c;
    in_if.last        <= lst;
    in_if.empty_token <= emp;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    parse_char(c, lst, emp);
    items_sent++;
    if (lst || emp) tokens_sent++;
  endtask

  task automatic send_token(input char_q_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1, 1'b0);
  endtask

  function automatic char_q_t chars_of(string s);
    char_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    return q;
  endfunction

  // Stops sending, waits until every predicted conversion has come out, and then
  // waits out the DrainCycles margin.
  task automatic settle_block();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (conversion_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [RadixW-1:0] b);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    base_reg = b;
    base_writes++;
  endtask

  // A digit that is valid in radix r where one exists; for radix 0 any digit.
  function automatic logic [ChW-1:0] digit_char(logic [RadixW-1:0] r);
    int unsigned top;
    int unsigned v;
    top = (r == 0) ? 36 : ((r > 36) ? 36 : r);
    v = $urandom_range(0, top - 1);
    if (v < 10) return CharZero + ChW'(v);
    if ($urandom_range(0, 1) == 0) return CharLowA + ChW'(v - 10);
    return CharUpA + ChW'(v - 10);
  endfunction

  // Any byte, or often one of the characters at the edges of the digit ranges
  // and the prefix and sign characters.
  function automatic logic [ChW-1:0] noise_char();
    logic [ChW-1:0] edges[17];
    edges = '{CharPercent, CharHash, CharDollar, CharQuote, CharMinus, CharZero,
              CharNine, CharLowA, CharLowZ, CharUpA, CharUpZ, 8'h2f, 8'h3a,
              8'h40, 8'h5b, 8'h60, 8'h7b};
    if ($urandom_range(0, 1) == 0) return ChW'($urandom_range(0, 255));
    return edges[$urandom_range(0, 16)];
  endfunction

  function automatic int unsigned digit_count();
    if ($urandom_range(0, 9) == 0) return $urandom_range(7, 20);
    return $urandom_range(1, 6);
  endfunction

  // One random token. Most are well formed with random digits, so that the
  // accumulator and sign paths see real work; the rest are broken forms,
  // noise and empty tokens.
  task automatic random_token();
    char_q_t t;
    int unsigned kind;
    int unsigned n;
    logic [RadixW-1:0] r;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      if ($urandom_range(0, 4) == 0) t.push_back(CharMinus);
      n = digit_count();
      repeat (n) t.push_back(digit_char(base_reg));
    end else if (kind < 55) begin
      case ($urandom_range(0, 2))
        0: begin
          t.push_back(CharPercent);
          r = RadixBin;
        end
        1: begin
          t.push_back(CharHash);
          r = RadixDec;
        end
        default: begin
          t.push_back(CharDollar);
          r = RadixHex;
        end
      endcase
      if ($urandom_range(0, 3) == 0) t.push_back(CharMinus);
      n = digit_count();
      repeat (n) t.push_back(digit_char(r));
    end else if (kind < 65) begin
      t = {CharQuote, ChW'($urandom_range(0, 255)), CharQuote};
    end else if (kind < 75) begin
      // A well-formed number with one character spoiled.
      if ($urandom_range(0, 1) == 0) t.push_back(CharDollar);
      n = $urandom_range(2, 6);
      repeat (n) t.push_back(digit_char(base_reg));
      t[$urandom_range(0, t.size() - 1)] = noise_char();
    end else if (kind < 85) begin
      n = $urandom_range(1, 6);
      repeat (n) t.push_back(noise_char());
    end else if (kind < 92) begin
      // The empty flag, sometimes cutting a token short, with last either way.
      n = $urandom_range(0, 3);
      repeat (n) send_char(noise_char(), 1'b0, 1'b0);
      send_char(ChW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      return;
    end else begin
      case ($urandom_range(0, 5))
        0: t = {CharDollar};
        1: t = {CharQuote};
        2: t = {CharQuote, noise_char()};
        3: t = {CharQuote, noise_char(), CharQuote, noise_char()};
        4: t = {CharMinus};
        default: t = {CharMinus, CharMinus, digit_char(base_reg)};
      endcase
    end
    send_token(t);
  endtask

  // Every form once, the sign and digit rules, the empty flag with last high
  // and low, and the lowest and highest character codes.
  task automatic test_directed();
    idle_on = 1'b1;
    send_token(chars_of("'A'"));
    send_token(chars_of("$-F"));
    send_token(chars_of("%1"));
    send_token(chars_of("#9"));
    send_token(chars_of("-z"));
    send_token(chars_of("--"));
    send_token(chars_of("$"));
    send_token(chars_of("'x"));
    send_char(CharZero, 1'b1, 1'b1);
    send_char(CharZero + 8'd1, 1'b0, 1'b0);
    send_char(CharZero + 8'd2, 1'b0, 1'b0);
    send_char(8'hff, 1'b0, 1'b1);
    send_char(8'h00, 1'b1, 1'b0);
    send_char(8'hff, 1'b1, 1'b0);
  endtask

  // Runs a few tokens under each radix setting, including the values that
  // accept no digit, only '0', or every letter.
  task automatic test_radix_settings();
    logic [RadixW-1:0] bases[8];
    bases = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63, 6'd16, 6'd10};
    foreach (bases[i]) begin
      write_base(bases[i]);
      send_token(chars_of("0"));
      send_token(chars_of("Zz9"));
      repeat (6) random_token();
    end
  endtask

  // Tokens longer than 255 characters, where the position counter has to
  // stick at its top value instead of wrapping back to the first position.
  task automatic test_long_tokens();
    char_q_t t;
    int unsigned n;
    for (int k = 0; k < 2; k++) begin
      t.delete();
      n = $urandom_range(257, 262);
      repeat (n) t.push_back(digit_char(base_reg));
      case (k)
        0: begin
          t[0] = CharDollar;
          t[256] = CharMinus;
        end
        default: begin
          t[0] = CharQuote;
          t[n - 1] = CharQuote;
        end
      endcase
      send_token(t);
    end
  endtask

  // The bulk of the run. Idling is switched on and off in stretches, and now
  // and then the sender holds off until the block is empty to load a new
  // default radix.
  task automatic test_random_tokens();
    int unsigned stop_at;
    int unsigned next_write;
    stop_at = items_sent + RandomItems;
    next_write = items_sent + 300;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      if (items_sent >= next_write) begin
        write_base(RadixW'($urandom_range(2, 36)));
        next_write = items_sent + 300;
      end
      random_token();
    end
    idle_on = 1'b1;
  endtask

  // Result side: after each result it draws a stall. A zero stall leaves
  // ready high; otherwise ready drops, and once a result shows up it is held
  // off for the drawn number of cycles before being taken.
  initial begin : result_check
    int unsigned stall;
    pnc_result_t want;
    out_if.ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        do @(posedge clk_i); while (out_if.valid !== 1'b1);
        repeat (stall - 1) @(posedge clk_i);
        @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      if (conversion_q.size() == 0) begin
        $error("result item with nothing expected: value %h ok %b",
               out_if.value, out_if.ok);
        fail_count++;
      end else begin
        want = conversion_q.pop_front();
        if (out_if.value !== want.value) begin
          $error("value mismatch: expected %h, actual %h", want.value, out_if.value);
          fail_count++;
        end
        if (out_if.ok !== want.ok) begin
          $error("ok mismatch: expected %b, actual %b", want.ok, out_if.ok);
          fail_count++;
        end
        if (want.ok) good_numbers++;
        else rejected_tokens++;
      end
    end
  end

  initial begin : watchdog
    #12_000_000;
    $display("prefixed_number_converter_top test failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.ch          = '0;
    in_if.last        = 1'b0;
    in_if.empty_token = 1'b0;
    base_reg          = DefaultBaseRst;
    idle_on           = 1'b1;
    fail_count        = 0;
    items_sent        = 0;
    tokens_sent       = 0;
    good_numbers      = 0;
    rejected_tokens   = 0;
    base_writes       = 0;
    clear_token();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_radix_settings();
    test_long_tokens();
    test_random_tokens();

    settle_block();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d character items in %0d tokens with %0d radix writes.",
             items_sent, tokens_sent, base_writes);
    $display("Checked %0d valid numbers and %0d rejected tokens.",
             good_numbers, rejected_tokens);
    if (fail_count == 0) begin
      $display("prefixed_number_converter_top test passed");
    end else begin
      $display("prefixed_number_converter_top test failed");
    end
    $finish;
  end

endmodule

[prefixed_number_converter_top.f]
hw/rtl/pnc_pkg.sv
hw/rtl/pnc_in_if.sv
hw/rtl/pnc_out_if.sv
hw/rtl/pnc_in_reg.sv
hw/rtl/pnc_token_core.sv
hw/rtl/pnc_out_reg.sv
hw/rtl/prefixed_number_converter_top.sv
verif/tb_prefixed_number_converter_top.sv
